### design/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the two-key sorted priority queue: operation
// codes, field widths, the stored entry and the per-cell control word.
// ----------------------------------------------------------------------------
package tpq_pkg;

    // default number of cells in the chain
    localparam int unsigned QUEUE_DEPTH_DEF = 64;

    // fixed field widths
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned PRIO_W  = 32;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned KEY_W   = FRAME_W + PRIO_W;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // one stored entry
    typedef struct packed {
        logic [FRAME_W-1:0]       frame;
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // one result transaction
    typedef struct packed {
        logic                     popped_valid;
        logic [FRAME_W-1:0]       popped_frame;
        logic signed [PRIO_W-1:0] popped_priority;
        logic [TAG_W-1:0]         popped_tag;
        logic [TAG_W-1:0]         head_tag;
        logic                     is_empty;
        logic [CNT_W-1:0]         entry_count;
        logic [CNT_W-1:0]         peak_count;
        logic [TOTAL_W-1:0]       push_total;
        logic                     rejected;
    } t_result;

    // unsigned key that orders like (frame, signed priority)
    function automatic logic [KEY_W-1:0] sort_key(input t_entry e);
        logic [KEY_W-1:0] k;
        k = {e.frame, ~e.prio[PRIO_W-1], e.prio[PRIO_W-2:0]};
        return k;
    endfunction

endpackage

### design/tpq_if.sv
// ----------------------------------------------------------------------------
// tpq_if
// Valid/ready channels of the sorted priority queue: operation requests in,
// status results out.
// ----------------------------------------------------------------------------
interface tpq_in_if;
    logic                               valid;
    logic                               ready;
    logic [tpq_pkg::MODE_W-1:0]         mode;
    logic [tpq_pkg::FRAME_W-1:0]        frame;
    logic signed [tpq_pkg::PRIO_W-1:0]  priority_req;
    logic [tpq_pkg::TAG_W-1:0]          tag;

    modport source (output valid, mode, frame, priority_req, tag, input ready);
    modport sink   (input valid, mode, frame, priority_req, tag, output ready);
endinterface

interface tpq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               popped_valid;
    logic [tpq_pkg::FRAME_W-1:0]        popped_frame;
    logic signed [tpq_pkg::PRIO_W-1:0]  popped_priority;
    logic [tpq_pkg::TAG_W-1:0]          popped_tag;
    logic [tpq_pkg::TAG_W-1:0]          head_tag;
    logic                               is_empty;
    logic [tpq_pkg::CNT_W-1:0]          entry_count;
    logic [tpq_pkg::CNT_W-1:0]          peak_count;
    logic [tpq_pkg::TOTAL_W-1:0]        push_total;
    logic                               rejected;

    modport source (output valid, popped_valid, popped_frame, popped_priority,
                    popped_tag, head_tag, is_empty, entry_count, peak_count,
                    push_total, rejected, input ready);
    modport sink   (input valid, popped_valid, popped_frame, popped_priority,
                    popped_tag, head_tag, is_empty, entry_count, peak_count,
                    push_total, rejected, output ready);
endinterface

### design/two_key_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// two_key_sorted_priority_queue_core
// Sorted queue of obligations ordered by frame, then signed priority, built
// as a chain of compare-and-shift cells with a two-entry result buffer.
// ----------------------------------------------------------------------------
// The queue takes one push, pop or clear per clock cycle and returns one
// result transaction per operation, valid the cycle after the request is
// accepted into an empty buffer. Each cell of the chain compares its own
// entry with the pushed key in parallel, so any insert or removal is done at
// once however full the queue is. Results wait in a two-entry output buffer,
// so the request side keeps flowing while one result is stalled; requests
// stop only when both buffer entries are full. Entries with equal keys leave
// in arrival order; a push into a full queue is dropped and flagged.
module two_key_sorted_priority_queue_core #(
    parameter int unsigned QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpq_in_if.sink    i_req,
    tpq_out_if.source o_rsp
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // cell chain wiring
    tpq_pkg::t_entry    w_entry [QUEUE_DEPTH];
    logic               w_keep  [QUEUE_DEPTH];
    tpq_pkg::t_entry    w_new;
    tpq_pkg::t_cell_ctl w_ctl;

    // status registers
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [CW-1:0]               r_peak;
    logic [CW-1:0]               n_peak;
    logic [tpq_pkg::TOTAL_W-1:0] r_push_total;
    logic [tpq_pkg::TOTAL_W-1:0] n_push_total;

    // result buffer
    logic              r_vld0;
    logic              r_vld1;
    tpq_pkg::t_result  r_res0;
    tpq_pkg::t_result  r_res1;
    tpq_pkg::t_result  w_res;

    logic w_in_acc;
    logic w_out_acc;
    logic w_is_push;
    logic w_is_pop;
    logic w_is_clear;
    logic w_full;
    logic w_push_ok;
    logic w_pop_ok;
    logic [tpq_pkg::TAG_W-1:0] w_head_tag;

    assign w_in_acc  = i_req.valid && i_req.ready;
    assign w_out_acc = o_rsp.valid && o_rsp.ready;

    // decode the operation
    always_comb begin
        w_is_push  = 1'b0;
        w_is_pop   = 1'b0;
        w_is_clear = 1'b0;
        unique case (i_req.mode)
            tpq_pkg::MODE_PUSH:  w_is_push  = 1'b1;
            tpq_pkg::MODE_POP:   w_is_pop   = 1'b1;
            tpq_pkg::MODE_CLEAR: w_is_clear = 1'b1;
            default: ;
        endcase
    end

    assign w_full    = (r_count == CW'(QUEUE_DEPTH));
    assign w_push_ok = w_is_push && !w_full;
    assign w_pop_ok  = w_is_pop && (r_count != '0);

    assign w_new.frame = i_req.frame;
    assign w_new.prio  = i_req.priority_req;
    assign w_new.tag   = i_req.tag;

    assign w_ctl.push = w_in_acc && w_push_ok;
    assign w_ctl.pop  = w_in_acc && w_pop_ok;

    // build the chain of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tpq_pkg::t_entry w_left;
        tpq_pkg::t_entry w_right;
        logic            w_left_keep;
        logic            w_occ;

        if (g == 0) begin : g_first
            assign w_left      = w_new;
            assign w_left_keep = 1'b1;
        end else begin : g_inner
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        assign w_occ = (CW'(g) < r_count);

        tpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_left_keep (w_left_keep),
            .i_occupied  (w_occ),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    // compute next counters
    always_comb begin
        n_count = r_count;
        if (w_push_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_pop_ok) begin
            n_count = r_count - CW'(1);
        end else if (w_is_clear) begin
            n_count = '0;
        end
        n_peak       = (n_count > r_peak) ? n_count : r_peak;
        n_push_total = r_push_total + tpq_pkg::TOTAL_W'(w_push_ok);
    end

    // pick the head tag as it stands after the operation
    always_comb begin
        w_head_tag = w_entry[0].tag;
        if (w_push_ok && !w_keep[0]) begin
            w_head_tag = i_req.tag;
        end else if (w_pop_ok) begin
            w_head_tag = w_entry[1].tag;
        end
        if (n_count == '0) begin
            w_head_tag = '0;
        end
    end

    // assemble the result transaction
    always_comb begin
        w_res.popped_valid    = w_pop_ok;
        w_res.popped_frame    = w_pop_ok ? w_entry[0].frame : '0;
        w_res.popped_priority = w_pop_ok ? w_entry[0].prio : '0;
        w_res.popped_tag      = w_pop_ok ? w_entry[0].tag : '0;
        w_res.head_tag        = w_head_tag;
        w_res.is_empty        = (n_count == '0);
        w_res.entry_count     = tpq_pkg::CNT_W'(n_count);
        w_res.peak_count      = tpq_pkg::CNT_W'(n_peak);
        w_res.push_total      = n_push_total;
        w_res.rejected        = w_is_push && w_full;
    end

    // advance status counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_peak       <= '0;
            r_push_total <= '0;
        end else if (w_in_acc) begin
            r_count      <= n_count;
            r_peak       <= n_peak;
            r_push_total <= n_push_total;
        end
    end

    // hold results in a two-entry buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (w_in_acc && w_out_acc) begin
                if (r_vld1) begin
                    r_res0 <= r_res1;
                    r_res1 <= w_res;
                end else begin
                    r_res0 <= w_res;
                end
            end else if (w_in_acc) begin
                if (r_vld0) begin
                    r_res1 <= w_res;
                    r_vld1 <= 1'b1;
                end else begin
                    r_res0 <= w_res;
                    r_vld0 <= 1'b1;
                end
            end else if (w_out_acc) begin
                r_res0 <= r_res1;
                r_vld0 <= r_vld1;
                r_vld1 <= 1'b0;
            end
        end
    end

    assign i_req.ready = !r_vld1;

    assign o_rsp.valid           = r_vld0;
    assign o_rsp.popped_valid    = r_res0.popped_valid;
    assign o_rsp.popped_frame    = r_res0.popped_frame;
    assign o_rsp.popped_priority = r_res0.popped_priority;
    assign o_rsp.popped_tag      = r_res0.popped_tag;
    assign o_rsp.head_tag        = r_res0.head_tag;
    assign o_rsp.is_empty        = r_res0.is_empty;
    assign o_rsp.entry_count     = r_res0.entry_count;
    assign o_rsp.peak_count      = r_res0.peak_count;
    assign o_rsp.push_total      = r_res0.push_total;
    assign o_rsp.rejected        = r_res0.rejected;

    // count stays within the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // peak never falls below the current count
    a_peak_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("peak count below entry count");

    // second buffer entry only fills behind the first
    a_buf_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> r_vld0)
        else $error("result buffer out of order");

    // an accepted clear empties the queue
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_clear) |=> (r_count == '0))
        else $error("queue not empty after clear");

    // a rejected push leaves the queue full and the push total unchanged
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_push && w_full) |=>
        (w_full && r_push_total == $past(r_push_total)))
        else $error("rejected push changed the queue");

endmodule

### design/tpq_cell.sv
// ----------------------------------------------------------------------------
// tpq_cell
// One slot of the sorted chain. Compares its entry against the pushed key,
// and on a push holds, takes the new entry or takes its left neighbor; on a
// pop takes its right neighbor.
// ----------------------------------------------------------------------------
module tpq_cell (
    input  logic               i_clk,
    input  tpq_pkg::t_cell_ctl i_ctl,
    input  tpq_pkg::t_entry    i_new,
    input  tpq_pkg::t_entry    i_left,
    input  tpq_pkg::t_entry    i_right,
    input  logic               i_left_keep,
    input  logic               i_occupied,
    output tpq_pkg::t_entry    o_entry,
    output logic               o_keep
);

    tpq_pkg::t_entry r_entry;
    tpq_pkg::t_entry n_entry;

    // keep the entry when the slot is occupied and it sorts at or before the pushed key
    assign o_keep = i_occupied &&
                    (tpq_pkg::sort_key(r_entry) <= tpq_pkg::sort_key(i_new));

    // select the next content of the slot
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    // hold the slot
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
